// ===== rtl/fba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fba_pkg: shared constants for the free block allocator
// Field widths, default depth, reset volume, operation and status codes, epoch width.
// ----------------------------------------------------------------------------
package fba_pkg;

  localparam int MAX_BLOCKS_DEF = 1024;

  localparam int CFG_W   = 11;
  localparam int OP_W    = 2;
  localparam int BLK_W   = 16;
  localparam int ST_W    = 3;
  localparam int GRANT_W = 10;
  localparam int SIZE_W  = 17;
  localparam int EPOCH_W = 8;

  localparam logic [CFG_W-1:0] VOL_RESET = 11'd1024;

  localparam logic [OP_W-1:0] OP_FORMAT  = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;
  localparam logic [OP_W-1:0] OP_UNLOAD  = 2'd3;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_NO_VOLUME = 3'd1;
  localparam logic [ST_W-1:0] ST_NO_FREE   = 3'd2;
  localparam logic [ST_W-1:0] ST_RANGE     = 3'd3;
  localparam logic [ST_W-1:0] ST_ALREADY   = 3'd4;

endpackage
`default_nettype wire

// ===== rtl/fba_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fba_if: channel interfaces of the free block allocator
// Request, response and configuration channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface fba_req_if;
  logic                        valid;
  logic                        ready;
  logic [fba_pkg::OP_W-1:0]    op;
  logic [fba_pkg::BLK_W-1:0]   block_number;

  modport source (output valid, output op, output block_number, input ready);
  modport sink   (input valid, input op, input block_number, output ready);
endinterface

interface fba_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [fba_pkg::ST_W-1:0]     status;
  logic [fba_pkg::GRANT_W-1:0]  granted_block;

  modport source (output valid, output status, output granted_block, input ready);
  modport sink   (input valid, input status, input granted_block, output ready);
endinterface

interface fba_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [fba_pkg::CFG_W-1:0]   volume_blocks;

  modport source (output valid, output volume_blocks, input ready);
  modport sink   (input valid, input volume_blocks, output ready);
endinterface
`default_nettype wire

// ===== rtl/fba_map.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fba_map: epoch-tagged membership map of stacked blocks
// One entry per block holds the epoch in which it was pushed; an entry of another
// epoch, or zero, means not stacked. Runs a clearing pass after reset and on request.
// ----------------------------------------------------------------------------
module fba_map #(
  parameter int DEPTH = fba_pkg::MAX_BLOCKS_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int EW    = fba_pkg::EPOCH_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clr_start,
  output logic          busy,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [EW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [EW-1:0] wr_data
);

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_data_r;
  logic          busy_r;
  logic [AW-1:0] clr_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_idx_r <= '0;
    end else if (busy_r) begin
      if (clr_idx_r == AW'(DEPTH - 1)) begin
        busy_r    <= 1'b0;
        clr_idx_r <= '0;
      end else begin
        clr_idx_r <= clr_idx_r + AW'(1);
      end
    end else if (clr_start) begin
      busy_r    <= 1'b1;
      clr_idx_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_idx_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // pass a same-cycle write straight through to the read register
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= (wr_en && wr_addr == rd_addr) ? wr_data : mem[rd_addr];
    end
  end

  assign busy    = busy_r;
  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== rtl/free_block_allocator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Flow: a taken request is registered in the request stage, its result in the
// result register. Throughput: one request per cycle while no reply stall, map
// sweep or epoch wrap holds in_req.ready low, set by the stack top read and
// the map read that are launched on the accepting edge. Reset: control state
// clears at once; a clearing pass then sweeps the membership map while
// in_req.ready is low. The same pass runs after every 255th format (epoch wrap).
// ----------------------------------------------------------------------------
// free_block_allocator_unit: volume block allocator with LIFO reuse
// Format, allocate, release and unload requests against a freed-block stack,
// a fresh-block counter and an epoch-tagged membership map.
// ----------------------------------------------------------------------------
module free_block_allocator_unit #(
  parameter int MAX_BLOCKS = fba_pkg::MAX_BLOCKS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  fba_req_if.sink        in_req,
  fba_rsp_if.source      out_rsp,
  fba_cfg_if.sink        cfg_wr
);

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int EW = fba_pkg::EPOCH_W;
  localparam int SW = fba_pkg::SIZE_W;
  localparam logic [SW-1:0] MaxSize = SW'(MAX_BLOCKS);

  // configuration
  logic [fba_pkg::CFG_W-1:0] vol_r;

  // request stage
  logic                       s1_valid_r;
  logic [fba_pkg::OP_W-1:0]   s1_op_r;
  logic [fba_pkg::BLK_W-1:0]  s1_blk_r;

  // allocator state
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] fresh_r, fresh_nxt;
  logic          loaded_r, loaded_nxt;
  logic [EW-1:0] ep_r, ep_nxt;

  // memories
  logic [AW-1:0] stack_mem [MAX_BLOCKS];
  logic [AW-1:0] stack_rd_r;
  logic [AW-1:0] top_addr;
  logic [EW-1:0] map_rd;
  logic          map_busy;
  logic          map_we;
  logic [AW-1:0] map_waddr;
  logic [EW-1:0] map_wdata;
  logic          clr_start;
  logic          push;

  // result register
  logic                         out_valid_r;
  logic [fba_pkg::ST_W-1:0]     status_r, status_nxt;
  logic [fba_pkg::GRANT_W-1:0]  granted_r, granted_nxt;

  logic          s1_fire;
  logic          wrap_hold;
  logic          in_ready;
  logic          accept;
  logic [SW-1:0] size;
  logic [SW-1:0] blk_w;
  logic [SW-1:0] fresh_w;

  assign s1_fire   = s1_valid_r && (!out_valid_r || out_rsp.ready);
  // a format that wraps the epoch starts a map sweep: take nothing behind it
  assign wrap_hold = s1_valid_r && s1_op_r == fba_pkg::OP_FORMAT && ep_r == '1;
  assign in_ready  = !map_busy && !wrap_hold && (!s1_valid_r || s1_fire);
  assign accept    = in_req.valid && in_ready;

  assign size    = (SW'(vol_r) > MaxSize) ? MaxSize : SW'(vol_r);
  assign blk_w   = SW'(s1_blk_r);
  assign fresh_w = SW'(fresh_r);

  always_comb begin
    count_nxt   = count_r;
    fresh_nxt   = fresh_r;
    loaded_nxt  = loaded_r;
    ep_nxt      = ep_r;
    status_nxt  = fba_pkg::ST_OK;
    granted_nxt = '0;
    push        = 1'b0;
    map_we      = 1'b0;
    map_waddr   = s1_blk_r[AW-1:0];
    map_wdata   = ep_r;
    clr_start   = 1'b0;
    if (s1_fire) begin
      if (s1_op_r == fba_pkg::OP_FORMAT) begin
        count_nxt  = '0;
        fresh_nxt  = CW'(1);
        loaded_nxt = 1'b1;
        if (ep_r == '1) begin
          ep_nxt    = EW'(1);
          clr_start = 1'b1;
        end else begin
          ep_nxt = ep_r + EW'(1);
        end
      end else if (!loaded_r) begin
        status_nxt = fba_pkg::ST_NO_VOLUME;
      end else begin
        case (s1_op_r)
          fba_pkg::OP_ALLOC: begin
            if (count_r != '0) begin
              count_nxt   = count_r - CW'(1);
              granted_nxt = fba_pkg::GRANT_W'(stack_rd_r);
              map_we      = 1'b1;
              map_waddr   = stack_rd_r;
              map_wdata   = '0;
            end else if (fresh_w < size) begin
              granted_nxt = fba_pkg::GRANT_W'(fresh_r);
              fresh_nxt   = fresh_r + CW'(1);
            end else begin
              status_nxt = fba_pkg::ST_NO_FREE;
            end
          end
          fba_pkg::OP_RELEASE: begin
            if (s1_blk_r == '0 || blk_w >= size) begin
              status_nxt = fba_pkg::ST_RANGE;
            end else if (map_rd == ep_r || blk_w >= fresh_w) begin
              status_nxt = fba_pkg::ST_ALREADY;
            end else if (count_r == CW'(MAX_BLOCKS)) begin
              status_nxt = fba_pkg::ST_ALREADY;
            end else begin
              push      = 1'b1;
              count_nxt = count_r + CW'(1);
              map_we    = 1'b1;
            end
          end
          fba_pkg::OP_UNLOAD: begin
            loaded_nxt = 1'b0;
          end
          default: begin
            status_nxt = fba_pkg::ST_OK;
          end
        endcase
      end
    end
  end

  // stack top after this cycle's request has taken effect
  assign top_addr = AW'(count_nxt - CW'(1));

  always_ff @(posedge clk) begin
    if (push) begin
      stack_mem[count_r[AW-1:0]] <= s1_blk_r[AW-1:0];
    end
  end

  // a push lands exactly on the next top: forward it
  always_ff @(posedge clk) begin
    if (accept) begin
      stack_rd_r <= push ? s1_blk_r[AW-1:0] : stack_mem[top_addr];
    end
  end

  fba_map #(
    .DEPTH (MAX_BLOCKS),
    .AW    (AW),
    .EW    (EW)
  ) u_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr_start (clr_start),
    .busy      (map_busy),
    .rd_en     (accept),
    .rd_addr   (in_req.block_number[AW-1:0]),
    .rd_data   (map_rd),
    .wr_en     (map_we),
    .wr_addr   (map_waddr),
    .wr_data   (map_wdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vol_r       <= fba_pkg::VOL_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      fresh_r     <= '0;
      loaded_r    <= 1'b0;
      ep_r        <= EW'(1);
    end else begin
      if (cfg_wr.valid) begin
        vol_r <= cfg_wr.volume_blocks;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
      count_r  <= count_nxt;
      fresh_r  <= fresh_nxt;
      loaded_r <= loaded_nxt;
      ep_r     <= ep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r  <= in_req.op;
      s1_blk_r <= in_req.block_number;
    end
    if (s1_fire) begin
      status_r  <= status_nxt;
      granted_r <= granted_nxt;
    end
  end

  assign in_req.ready          = in_ready;
  assign cfg_wr.ready          = 1'b1;
  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.status        = status_r;
  assign out_rsp.granted_block = granted_r;

endmodule
`default_nettype wire

// ===== rtl/fba_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fba_checker: port-level checks for the free block allocator
// Watches the top level's channels and is bound to it below.
// ----------------------------------------------------------------------------
module fba_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [fba_pkg::ST_W-1:0]     status,
  input logic [fba_pkg::GRANT_W-1:0]  granted_block
);

  // the map sweep started by reset holds off request beats as reset ends
  a_sweep_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("request taken during map sweep after reset");

  // a failed request never grants a block
  a_no_grant_on_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && status != fba_pkg::ST_OK) |-> granted_block == '0)
    else $error("block granted with a fault status");

  a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(status) && $stable(granted_block)))
    else $error("result beat changed while stalled");

endmodule

bind free_block_allocator_unit fba_checker u_fba_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_req.ready),
  .out_valid     (out_rsp.valid),
  .out_ready     (out_rsp.ready),
  .status        (out_rsp.status),
  .granted_block (out_rsp.granted_block)
);
`default_nettype wire

// ===== tb/free_block_allocator_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_block_allocator_unit_tb: self-checking bench for the block allocator
// The bench sends format, allocate, release and unload requests. The sender
// works in bursts with gaps, and the reply side stalls on its own pattern.
// A private copy of the freed-block stack, the membership map and the
// counters predicts every reply. Replies are checked in order, field by field.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [fba_pkg::ST_W-1:0]    status;
  logic [fba_pkg::GRANT_W-1:0] granted;
} reply_t;

class alloc_ledger;
  localparam int DEPTH = fba_pkg::MAX_BLOCKS_DEF;

  logic [fba_pkg::CFG_W-1:0]   volume_blocks;
  logic [fba_pkg::GRANT_W-1:0] freed_blocks [DEPTH];
  bit                          listed [DEPTH];
  int unsigned                 depth_used;
  int unsigned                 fresh_next;
  bit                          loaded;
  int unsigned                 noted;
  reply_t                      replies [$];

  function new();
    volume_blocks = fba_pkg::VOL_RESET;
    depth_used    = 0;
    fresh_next    = 0;
    loaded        = 1'b0;
    noted         = 0;
    foreach (listed[i]) listed[i] = 1'b0;
  endfunction

  // size as the block sees it: register value capped at the map depth
  function int unsigned span();
    return (volume_blocks > DEPTH) ? DEPTH : volume_blocks;
  endfunction

  function void note_request(input logic [fba_pkg::OP_W-1:0] op,
                             input logic [fba_pkg::BLK_W-1:0] blk);
    reply_t      r;
    int unsigned lim;
    r.status  = fba_pkg::ST_OK;
    r.granted = '0;
    lim       = span();
    noted++;
    if (op == fba_pkg::OP_FORMAT) begin
      foreach (listed[i]) listed[i] = 1'b0;
      depth_used = 0;
      fresh_next = 1;
      loaded     = 1'b1;
    end else if (!loaded) begin
      r.status = fba_pkg::ST_NO_VOLUME;
    end else begin
      case (op)
        fba_pkg::OP_ALLOC: begin
          if (depth_used > 0) begin
            // most recently released first, even if above a shrunk size
            depth_used--;
            r.granted = freed_blocks[depth_used];
            listed[r.granted] = 1'b0;
          end else if (fresh_next < lim) begin
            r.granted = fba_pkg::GRANT_W'(fresh_next);
            fresh_next++;
          end else begin
            r.status = fba_pkg::ST_NO_FREE;
          end
        end
        fba_pkg::OP_RELEASE: begin
          if (blk == 0 || blk >= lim) begin
            r.status = fba_pkg::ST_RANGE;
          end else if (listed[blk] || blk >= fresh_next) begin
            r.status = fba_pkg::ST_ALREADY;
          end else begin
            freed_blocks[depth_used] = fba_pkg::GRANT_W'(blk);
            depth_used++;
            listed[blk] = 1'b1;
          end
        end
        fba_pkg::OP_UNLOAD: loaded = 1'b0;
        default: ;
      endcase
    end
    replies.push_back(r);
  endfunction

  function bit check_reply(input logic [fba_pkg::ST_W-1:0] status,
                           input logic [fba_pkg::GRANT_W-1:0] granted,
                           output string why);
    reply_t want;
    why = "";
    if (replies.size() == 0) begin
      why = $sformatf("reply with nothing outstanding: status %0d block %0d", status, granted);
      return 1'b0;
    end
    want = replies.pop_front();
    if (status !== want.status)
      why = $sformatf("status %0d, expected %0d;", status, want.status);
    if (granted !== want.granted)
      why = {why, $sformatf(" block %0d, expected %0d", granted, want.granted)};
    return why.len() == 0;
  endfunction
endclass

module free_block_allocator_unit_tb;
  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 80;
  localparam int HOLD_AFTER   = 300;

  logic clk = 1'b0;
  logic rst_n;

  fba_req_if req_ch();
  fba_rsp_if rsp_ch();
  fba_cfg_if cfg_ch();

  alloc_ledger ledger = new();

  int mismatches  = 0;
  int cycles      = 0;
  int beats_taken = 0;
  int sent_items  = 0;
  int burst_left  = 0;

  free_block_allocator_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch),
    .cfg_wr  (cfg_ch)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("[%0t] reply mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin
    string why;
    if (rst_n) begin
      if (req_ch.valid && req_ch.ready) begin
        ledger.note_request(req_ch.op, req_ch.block_number);
        beats_taken <= beats_taken + 1;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (!ledger.check_reply(rsp_ch.status, rsp_ch.granted_block, why))
          report_mismatch(why);
      end
    end
  end

  // reply side: rotate through stall patterns, with one long hold-off
  initial begin
    int tick;
    bit held;
    bit take;
    tick = 0;
    held = 1'b0;
    rsp_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      tick++;
      if (!held && beats_taken >= HOLD_AFTER) begin
        held = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      case ((tick / 64) % 4)
        0:       take = 1'b1;
        1:       take = ($urandom_range(3) != 0);
        2:       take = ($urandom_range(3) == 0);
        default: take = ((tick % 3) == 0);
      endcase
      rsp_ch.ready <= take;
    end
  end

  task automatic send_item(input logic [fba_pkg::OP_W-1:0] op,
                           input logic [fba_pkg::BLK_W-1:0] blk);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(6);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(24, 1);
    end
    burst_left--;
    req_ch.valid        <= 1'b1;
    req_ch.op           <= op;
    req_ch.block_number <= blk;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sent_items++;
  endtask

  task automatic wait_drained();
    while (ledger.noted != sent_items || ledger.replies.size() != 0) @(posedge clk);
  endtask

  task automatic set_volume(input logic [fba_pkg::CFG_W-1:0] vol);
    req_ch.valid <= 1'b0;
    wait_drained();
    cfg_ch.valid         <= 1'b1;
    cfg_ch.volume_blocks <= vol;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    ledger.volume_blocks = vol;
  endtask

  // mostly blocks that are out, some already stacked, some at the size edge
  function automatic logic [fba_pkg::BLK_W-1:0] pick_block();
    int unsigned r;
    int unsigned lim;
    r   = $urandom_range(99);
    lim = ledger.span();
    if (r < 50 && ledger.fresh_next > 1)
      return fba_pkg::BLK_W'($urandom_range(ledger.fresh_next - 1, 1));
    if (r < 65 && ledger.depth_used > 0)
      return fba_pkg::BLK_W'(ledger.freed_blocks[$urandom_range(ledger.depth_used - 1)]);
    if (r < 80)
      return fba_pkg::BLK_W'(lim + $urandom_range(2) - 1);
    if (r < 85)
      return '0;
    return fba_pkg::BLK_W'($urandom());
  endfunction

  task automatic run_phase(input logic [fba_pkg::CFG_W-1:0] vol, input int items,
                           input int alloc_pct, input int fmt_pct, input int unl_pct);
    int r;
    logic [fba_pkg::OP_W-1:0] op;
    set_volume(vol);
    repeat (items) begin
      r = $urandom_range(99);
      if (r < fmt_pct || (!ledger.loaded && $urandom_range(7) == 0))
        op = fba_pkg::OP_FORMAT;
      else if (r < fmt_pct + unl_pct)
        op = fba_pkg::OP_UNLOAD;
      else if ($urandom_range(99) < alloc_pct)
        op = fba_pkg::OP_ALLOC;
      else
        op = fba_pkg::OP_RELEASE;
      send_item(op, (op == fba_pkg::OP_RELEASE) ? pick_block()
                                                : fba_pkg::BLK_W'($urandom()));
    end
  endtask

  initial begin
    rst_n                <= 1'b0;
    req_ch.valid         <= 1'b0;
    req_ch.op            <= fba_pkg::OP_FORMAT;
    req_ch.block_number  <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.volume_blocks <= fba_pkg::VOL_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: back-to-back beats, no volume first, then the reset size
    burst_left = 1 << 20;
    send_item(fba_pkg::OP_ALLOC, '0);
    send_item(fba_pkg::OP_RELEASE, 16'd1);
    send_item(fba_pkg::OP_UNLOAD, '0);
    send_item(fba_pkg::OP_FORMAT, '0);
    send_item(fba_pkg::OP_ALLOC, '0);
    send_item(fba_pkg::OP_ALLOC, '1);
    send_item(fba_pkg::OP_RELEASE, 16'd0);
    send_item(fba_pkg::OP_RELEASE, 16'hFFFF);
    send_item(fba_pkg::OP_RELEASE, 16'd1023);
    send_item(fba_pkg::OP_RELEASE, 16'd1);
    send_item(fba_pkg::OP_RELEASE, 16'd1);
    send_item(fba_pkg::OP_RELEASE, 16'd2);
    send_item(fba_pkg::OP_ALLOC, '0);
    send_item(fba_pkg::OP_FORMAT, '0);
    send_item(fba_pkg::OP_UNLOAD, '0);
    // exhaust a small volume, then shrink it under a stacked block
    set_volume(11'd4);
    send_item(fba_pkg::OP_FORMAT, '0);
    send_item(fba_pkg::OP_ALLOC, '0);
    send_item(fba_pkg::OP_ALLOC, '0);
    send_item(fba_pkg::OP_ALLOC, '0);
    send_item(fba_pkg::OP_ALLOC, '0);
    send_item(fba_pkg::OP_RELEASE, 16'd3);
    set_volume(11'd2);
    send_item(fba_pkg::OP_RELEASE, 16'd2);
    send_item(fba_pkg::OP_ALLOC, '0);
    send_item(fba_pkg::OP_ALLOC, '0);
    set_volume(11'd1);
    send_item(fba_pkg::OP_ALLOC, '0);
    send_item(fba_pkg::OP_FORMAT, '0);
    send_item(fba_pkg::OP_ALLOC, '0);

    burst_left = 0;
    run_phase(11'd12, 150, 50, 3, 3);
    run_phase(11'd3, 80, 55, 5, 3);
    run_phase(11'd2047, 90, 60, 2, 2);
    run_phase(11'd40, 120, 65, 3, 0);
    // shrink while loaded: no forced format at the start
    run_phase(11'd9, 100, 40, 0, 0);
    run_phase(11'd1, 40, 50, 6, 4);
    run_phase(11'd0, 30, 50, 6, 4);
    // heavy formatting, enough to wrap the map epoch
    run_phase(11'd16, 450, 40, 60, 2);
    run_phase(11'd2, 60, 50, 5, 3);
    run_phase(11'd1024, 100, 50, 3, 3);

    req_ch.valid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule
